>>> rtl/mres_pkg.sv
// shared types, constants and register codes for the multi-rate event scheduler
`default_nettype none

package mres_pkg;

   // field widths
   localparam int unsigned TimeWidth    = 64;
   localparam int unsigned PeriodWidth  = 32;
   localparam int unsigned CountWidth   = 16;
   localparam int unsigned LineWidth    = 10;
   localparam int unsigned TotalWidth   = 32;
   localparam int unsigned StatusWidth  = 4;
   localparam int unsigned PulseWidth   = 3;
   localparam int unsigned ModeWidth    = 2;
   localparam int unsigned TimerCount   = 3;

   // configuration port geometry
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   // video timing and interval timer constants
   localparam int unsigned LinesPerFrame   = 525;
   localparam int unsigned LastVisibleLine = 479;
   localparam int unsigned PitDecrement    = 10;

   // register reset values
   localparam logic [PeriodWidth-1:0] DefaultPeriod = PeriodWidth'(1000);
   localparam logic [PeriodWidth-1:0] BlasterOff    = '0;

   // register index codes
   typedef enum logic [2:0] {
      REG_SCANLINE_PERIOD = 3'd0,
      REG_IRQ0_PERIOD     = 3'd1,
      REG_PIT_PERIOD      = 3'd2,
      REG_SPEECH_PERIOD   = 3'd3,
      REG_BLASTER_PERIOD  = 3'd4,
      REG_SAMPLE_PERIOD   = 3'd5,
      REG_ADLIB_PERIOD    = 3'd6,
      REG_AUDIO_MODE      = 3'd7
   } reg_idx_type;

   // audio mode codes; the unused code behaves as slow mode
   typedef enum logic [ModeWidth-1:0] {
      AUDIO_OFF    = 2'd0,
      AUDIO_NORMAL = 2'd1,
      AUDIO_SLOW   = 2'd2,
      AUDIO_SPARE  = 2'd3
   } audio_mode_type;

   localparam logic [PulseWidth-1:0] NormalTicks = PulseWidth'(1);
   localparam logic [PulseWidth-1:0] SlowTicks   = PulseWidth'(4);

   // configuration registers as seen by the scheduling logic
   typedef struct packed {
      logic [PeriodWidth-1:0] scanline_period;
      logic [PeriodWidth-1:0] irq0_period;
      logic [PeriodWidth-1:0] pit_period;
      logic [PeriodWidth-1:0] speech_period;
      logic [PeriodWidth-1:0] blaster_period;
      logic [PeriodWidth-1:0] sample_period;
      logic [PeriodWidth-1:0] adlib_period;
      audio_mode_type         audio_mode;
   } cfg_type;

   // one input item
   typedef struct packed {
      logic [TimeWidth-1:0]  now_time;
      logic [TimerCount-1:0] timer_active;
      logic [CountWidth-1:0] reload_zero;
      logic [CountWidth-1:0] reload_one;
      logic [CountWidth-1:0] reload_two;
   } req_type;

   // one result item
   typedef struct packed {
      logic                   irq0_request;
      logic                   speech_pulse;
      logic                   blaster_pulse;
      logic [PulseWidth-1:0]  audio_pulses;
      logic                   fm_pulse;
      logic [LineWidth-1:0]   line_number;
      logic [StatusWidth-1:0] video_status;
      logic [TotalWidth-1:0]  line_count;
      logic [CountWidth-1:0]  count_zero;
      logic [CountWidth-1:0]  count_one;
      logic [CountWidth-1:0]  count_two;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/mres_due.sv
// deadline check for one periodic channel: now at or past last time plus period
`default_nettype none

module mres_due (
   input  wire logic [mres_pkg::TimeWidth-1:0]   now_time,
   input  wire logic [mres_pkg::TimeWidth-1:0]   last_time,
   input  wire logic [mres_pkg::PeriodWidth-1:0] period,
   output logic                                  due
);

   logic [mres_pkg::TimeWidth-1:0] elapsed;

   // elapsed time only counts when time has not gone backwards
   assign elapsed = now_time - last_time;
   assign due     = (now_time >= last_time) &&
                    (elapsed >= mres_pkg::TimeWidth'(period));

endmodule

`default_nettype wire

>>> rtl/mres_csr.sv
// configuration register file behind the apb-style port
`default_nettype none

module mres_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [mres_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  wire logic [mres_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic      [mres_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                                     csr_pready,
   output mres_pkg::cfg_type                        cfg
);

   mres_pkg::cfg_type     cfg_ff;
   mres_pkg::reg_idx_type reg_idx;
   logic                  wr_en;

   assign reg_idx    = mres_pkg::reg_idx_type'(csr_paddr[mres_pkg::CsrAddrWidth-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scanline_period <= mres_pkg::DefaultPeriod;
         cfg_ff.irq0_period     <= mres_pkg::DefaultPeriod;
         cfg_ff.pit_period      <= mres_pkg::DefaultPeriod;
         cfg_ff.speech_period   <= mres_pkg::DefaultPeriod;
         cfg_ff.blaster_period  <= mres_pkg::BlasterOff;
         cfg_ff.sample_period   <= mres_pkg::DefaultPeriod;
         cfg_ff.adlib_period    <= mres_pkg::DefaultPeriod;
         cfg_ff.audio_mode      <= mres_pkg::AUDIO_NORMAL;
      end else if (wr_en) begin
         case (reg_idx)
            mres_pkg::REG_SCANLINE_PERIOD: cfg_ff.scanline_period <= csr_pwdata;
            mres_pkg::REG_IRQ0_PERIOD:     cfg_ff.irq0_period     <= csr_pwdata;
            mres_pkg::REG_PIT_PERIOD:      cfg_ff.pit_period      <= csr_pwdata;
            mres_pkg::REG_SPEECH_PERIOD:   cfg_ff.speech_period   <= csr_pwdata;
            mres_pkg::REG_BLASTER_PERIOD:  cfg_ff.blaster_period  <= csr_pwdata;
            mres_pkg::REG_SAMPLE_PERIOD:   cfg_ff.sample_period   <= csr_pwdata;
            mres_pkg::REG_ADLIB_PERIOD:    cfg_ff.adlib_period    <= csr_pwdata;
            mres_pkg::REG_AUDIO_MODE: begin
               cfg_ff.audio_mode <=
                  mres_pkg::audio_mode_type'(csr_pwdata[mres_pkg::ModeWidth-1:0]);
            end
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_idx)
         mres_pkg::REG_SCANLINE_PERIOD: csr_prdata = cfg_ff.scanline_period;
         mres_pkg::REG_IRQ0_PERIOD:     csr_prdata = cfg_ff.irq0_period;
         mres_pkg::REG_PIT_PERIOD:      csr_prdata = cfg_ff.pit_period;
         mres_pkg::REG_SPEECH_PERIOD:   csr_prdata = cfg_ff.speech_period;
         mres_pkg::REG_BLASTER_PERIOD:  csr_prdata = cfg_ff.blaster_period;
         mres_pkg::REG_SAMPLE_PERIOD:   csr_prdata = cfg_ff.sample_period;
         mres_pkg::REG_ADLIB_PERIOD:    csr_prdata = cfg_ff.adlib_period;
         mres_pkg::REG_AUDIO_MODE: begin
            csr_prdata = mres_pkg::CsrDataWidth'(cfg_ff.audio_mode);
         end
         default: csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/mres_core.sv
// channel state and single-pass update of all seven periodic channels
`default_nettype none

module mres_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire mres_pkg::req_type item,
   input  wire mres_pkg::cfg_type cfg,
   output mres_pkg::rsp_type      result
);

   localparam int unsigned TW = mres_pkg::TimeWidth;
   localparam int unsigned CW = mres_pkg::CountWidth;
   localparam int unsigned LW = mres_pkg::LineWidth;
   localparam int unsigned NT = mres_pkg::TimerCount;

   // channel state
   logic [TW-1:0] last_scan_ff,    last_scan_in;
   logic [TW-1:0] last_irq_ff,     last_irq_in;
   logic [TW-1:0] last_pit_ff,     last_pit_in;
   logic [TW-1:0] last_speech_ff,  last_speech_in;
   logic [TW-1:0] last_blaster_ff, last_blaster_in;
   logic [TW-1:0] last_sample_ff,  last_sample_in;
   logic [TW-1:0] last_fm_ff,      last_fm_in;
   logic [LW-1:0] line_ff,         line_in;
   logic [mres_pkg::TotalWidth-1:0]  total_ff,  total_in;
   logic [mres_pkg::StatusWidth-1:0] status_ff, status_in;
   logic [CW-1:0] counts_ff [NT];
   logic [CW-1:0] counts_in [NT];
   logic [CW-1:0] reload    [NT];

   logic scan_due, irq_due, pit_due, speech_due, blaster_due, sample_due, fm_due;
   logic irq_fire, blaster_fire, sample_fire;
   logic [LW:0] line_sum;
   logic [CW-1:0] count_base [NT];

   // deadline checks, one per channel
   mres_due u_due_scan (
      .now_time(item.now_time), .last_time(last_scan_ff),
      .period(cfg.scanline_period), .due(scan_due));
   mres_due u_due_irq (
      .now_time(item.now_time), .last_time(last_irq_ff),
      .period(cfg.irq0_period), .due(irq_due));
   mres_due u_due_pit (
      .now_time(item.now_time), .last_time(last_pit_ff),
      .period(cfg.pit_period), .due(pit_due));
   mres_due u_due_speech (
      .now_time(item.now_time), .last_time(last_speech_ff),
      .period(cfg.speech_period), .due(speech_due));
   mres_due u_due_blaster (
      .now_time(item.now_time), .last_time(last_blaster_ff),
      .period(cfg.blaster_period), .due(blaster_due));
   mres_due u_due_sample (
      .now_time(item.now_time), .last_time(last_sample_ff),
      .period(cfg.sample_period), .due(sample_due));
   mres_due u_due_fm (
      .now_time(item.now_time), .last_time(last_fm_ff),
      .period(cfg.adlib_period), .due(fm_due));

   assign irq_fire     = item.timer_active[0] && irq_due;
   assign blaster_fire = (cfg.blaster_period != '0) && blaster_due;
   assign sample_fire  = (cfg.audio_mode != mres_pkg::AUDIO_OFF) && sample_due;

   assign reload[0] = item.reload_zero;
   assign reload[1] = item.reload_one;
   assign reload[2] = item.reload_two;

   // scanline counter wraps at the frame length
   assign line_sum = {1'b0, line_ff} + (LW+1)'(1);

   always_comb begin
      line_in   = line_ff;
      status_in = status_ff;
      total_in  = total_ff;
      last_scan_in = last_scan_ff;
      if (scan_due) begin
         if (line_sum >= (LW+1)'(mres_pkg::LinesPerFrame)) begin
            line_in = LW'(line_sum - (LW+1)'(mres_pkg::LinesPerFrame));
         end else begin
            line_in = line_sum[LW-1:0];
         end
         status_in = {(line_in > LW'(mres_pkg::LastVisibleLine)), 2'b00, line_in[0]};
         total_in  = total_ff + mres_pkg::TotalWidth'(1);
         last_scan_in = item.now_time;
      end
   end

   // interval timer counters: reload below the decrement, then count down
   always_comb begin
      last_pit_in = pit_due ? item.now_time : last_pit_ff;
      for (int ch = 0; ch < NT; ch++) begin
         count_base[ch] = (counts_ff[ch] < CW'(mres_pkg::PitDecrement)) ?
                          reload[ch] : counts_ff[ch];
         if (pit_due && item.timer_active[ch]) begin
            counts_in[ch] = count_base[ch] - CW'(mres_pkg::PitDecrement);
         end else begin
            counts_in[ch] = counts_ff[ch];
         end
      end
   end

   // re-arm: irq to the current time, audio channels by their period
   assign last_irq_in     = irq_fire ? item.now_time : last_irq_ff;
   assign last_speech_in  = speech_due ? last_speech_ff + TW'(cfg.speech_period)
                                       : last_speech_ff;
   assign last_blaster_in = blaster_fire ? last_blaster_ff + TW'(cfg.blaster_period)
                                         : last_blaster_ff;
   assign last_sample_in  = sample_fire ? last_sample_ff + TW'(cfg.sample_period)
                                        : last_sample_ff;
   assign last_fm_in      = fm_due ? last_fm_ff + TW'(cfg.adlib_period) : last_fm_ff;

   // result item
   always_comb begin
      result.irq0_request  = irq_fire;
      result.speech_pulse  = speech_due;
      result.blaster_pulse = blaster_fire;
      if (!sample_fire) begin
         result.audio_pulses = '0;
      end else if (cfg.audio_mode == mres_pkg::AUDIO_NORMAL) begin
         result.audio_pulses = mres_pkg::NormalTicks;
      end else begin
         result.audio_pulses = mres_pkg::SlowTicks;
      end
      result.fm_pulse      = fm_due;
      result.line_number   = line_in;
      result.video_status  = status_in;
      result.line_count    = total_in;
      result.count_zero    = counts_in[0];
      result.count_one     = counts_in[1];
      result.count_two     = counts_in[2];
   end

   // state update once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         last_scan_ff    <= '0;
         last_irq_ff     <= '0;
         last_pit_ff     <= '0;
         last_speech_ff  <= '0;
         last_blaster_ff <= '0;
         last_sample_ff  <= '0;
         last_fm_ff      <= '0;
         line_ff         <= '0;
         total_ff        <= '0;
         status_ff       <= '0;
         for (int ch = 0; ch < NT; ch++) begin
            counts_ff[ch] <= '0;
         end
      end else if (step) begin
         last_scan_ff    <= last_scan_in;
         last_irq_ff     <= last_irq_in;
         last_pit_ff     <= last_pit_in;
         last_speech_ff  <= last_speech_in;
         last_blaster_ff <= last_blaster_in;
         last_sample_ff  <= last_sample_in;
         last_fm_ff      <= last_fm_in;
         line_ff         <= line_in;
         total_ff        <= total_in;
         status_ff       <= status_in;
         for (int ch = 0; ch < NT; ch++) begin
            counts_ff[ch] <= counts_in[ch];
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/multi_rate_event_scheduler.sv
// top level: input register, channel update, result register and config port
`default_nettype none

// Multi-rate event scheduler. Each item carries the host time and the interval
// timer state; the block checks seven periodic channels (scanline, IRQ0, timer,
// speech, blaster, sample, FM) and returns one result item per input item with
// the pulses fired and the updated scanline and timer counters. An item is taken
// every clock cycle unless req_stall holds it; it passes through the input register
// and then the result register, and the longest path between them is the 64-bit
// subtract and compare of each channel's deadline check. The result register
// lets a new item be taken while a finished result still waits downstream.
// Configuration registers sit at byte addresses 4*i; the user must write them only
// while the block is idle, as the block itself does not enforce this.

module multi_rate_event_scheduler (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // input items
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [mres_pkg::TimeWidth-1:0]          req_now_time,
   input  wire logic [mres_pkg::TimerCount-1:0]         req_timer_active,
   input  wire logic [mres_pkg::CountWidth-1:0]         req_reload_zero,
   input  wire logic [mres_pkg::CountWidth-1:0]         req_reload_one,
   input  wire logic [mres_pkg::CountWidth-1:0]         req_reload_two,
   // result items
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic                                         rsp_irq0_request,
   output logic                                         rsp_speech_pulse,
   output logic                                         rsp_blaster_pulse,
   output logic      [mres_pkg::PulseWidth-1:0]         rsp_audio_pulses,
   output logic                                         rsp_fm_pulse,
   output logic      [mres_pkg::LineWidth-1:0]          rsp_line_number,
   output logic      [mres_pkg::StatusWidth-1:0]        rsp_video_status,
   output logic      [mres_pkg::TotalWidth-1:0]         rsp_line_count,
   output logic      [mres_pkg::CountWidth-1:0]         rsp_count_zero,
   output logic      [mres_pkg::CountWidth-1:0]         rsp_count_one,
   output logic      [mres_pkg::CountWidth-1:0]         rsp_count_two,
   // configuration port
   input  wire logic                                    csr_psel,
   input  wire logic                                    csr_penable,
   input  wire logic                                    csr_pwrite,
   input  wire logic [mres_pkg::CsrAddrWidth-1:0]       csr_paddr,
   input  wire logic [mres_pkg::CsrDataWidth-1:0]       csr_pwdata,
   output logic      [mres_pkg::CsrDataWidth-1:0]       csr_prdata,
   output logic                                         csr_pready
);

   mres_pkg::cfg_type cfg;
   mres_pkg::req_type req_item;
   mres_pkg::req_type in_item_ff;
   mres_pkg::rsp_type rsp_item_in;
   mres_pkg::rsp_type rsp_item_ff;
   logic              in_valid_ff;
   logic              rsp_valid_ff;
   logic              advance;
   logic              step;

   // configuration registers
   mres_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake: the result register frees up when empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign step      = in_valid_ff && advance;

   assign req_item.now_time     = req_now_time;
   assign req_item.timer_active = req_timer_active;
   assign req_item.reload_zero  = req_reload_zero;
   assign req_item.reload_one   = req_reload_one;
   assign req_item.reload_two   = req_reload_two;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
   end

   // channel update
   mres_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (rsp_item_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_irq0_request  = rsp_item_ff.irq0_request;
   assign rsp_speech_pulse  = rsp_item_ff.speech_pulse;
   assign rsp_blaster_pulse = rsp_item_ff.blaster_pulse;
   assign rsp_audio_pulses  = rsp_item_ff.audio_pulses;
   assign rsp_fm_pulse      = rsp_item_ff.fm_pulse;
   assign rsp_line_number   = rsp_item_ff.line_number;
   assign rsp_video_status  = rsp_item_ff.video_status;
   assign rsp_line_count    = rsp_item_ff.line_count;
   assign rsp_count_zero    = rsp_item_ff.count_zero;
   assign rsp_count_one     = rsp_item_ff.count_one;
   assign rsp_count_two     = rsp_item_ff.count_two;

   // an accepted item always lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> in_valid_ff)
      else $error("accepted item missing from input register");

   // scanline stays inside the frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_number < mres_pkg::LineWidth'(mres_pkg::LinesPerFrame)))
      else $error("scanline outside frame");

   // status bits follow the scanline once it has advanced
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_line_count != '0)) |->
         ((rsp_video_status[0] == rsp_line_number[0]) &&
          (rsp_video_status[3] ==
             (rsp_line_number > mres_pkg::LineWidth'(mres_pkg::LastVisibleLine))) &&
          (rsp_video_status[2:1] == 2'b00)))
      else $error("video status does not match scanline");

   // sample ticks come as none, one or four
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_audio_pulses == '0) ||
                     (rsp_audio_pulses == mres_pkg::NormalTicks) ||
                     (rsp_audio_pulses == mres_pkg::SlowTicks)))
      else $error("bad sample tick count");

   // blaster never fires while disabled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cfg.blaster_period == '0)) |-> !rsp_blaster_pulse)
      else $error("blaster fired while disabled");

endmodule

`default_nettype wire

>>> test/mres_checker.sv
// checker for the multi-rate event scheduler: predicts every result item and compares it
`timescale 1ns / 100ps

module mres_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input channel
   input  wire logic                                 req_valid,
   input  wire logic                                 req_stall,
   input  wire logic [mres_pkg::TimeWidth-1:0]       req_now_time,
   input  wire logic [mres_pkg::TimerCount-1:0]      req_timer_active,
   input  wire logic [mres_pkg::CountWidth-1:0]      req_reload_zero,
   input  wire logic [mres_pkg::CountWidth-1:0]      req_reload_one,
   input  wire logic [mres_pkg::CountWidth-1:0]      req_reload_two,
   // result channel
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   input  wire logic                                 rsp_irq0_request,
   input  wire logic                                 rsp_speech_pulse,
   input  wire logic                                 rsp_blaster_pulse,
   input  wire logic [mres_pkg::PulseWidth-1:0]      rsp_audio_pulses,
   input  wire logic                                 rsp_fm_pulse,
   input  wire logic [mres_pkg::LineWidth-1:0]       rsp_line_number,
   input  wire logic [mres_pkg::StatusWidth-1:0]     rsp_video_status,
   input  wire logic [mres_pkg::TotalWidth-1:0]      rsp_line_count,
   input  wire logic [mres_pkg::CountWidth-1:0]      rsp_count_zero,
   input  wire logic [mres_pkg::CountWidth-1:0]      rsp_count_one,
   input  wire logic [mres_pkg::CountWidth-1:0]      rsp_count_two,
   // configuration port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic                                 csr_pready,
   input  wire logic [mres_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  wire logic [mres_pkg::CsrDataWidth-1:0]    csr_pwdata,
   // status towards the testbench top
   output int unsigned                               mismatch_count,
   output int unsigned                               pending
);
   import mres_pkg::*;

   localparam int unsigned MaxReports = 10;
   localparam int unsigned RetraceBit = 3;
   localparam int unsigned OddLineBit = 0;

   // register copy as the block should hold it
   cfg_type cfg;

   // last firing time of each channel
   logic [TimeWidth-1:0] stamp_line, stamp_irq, stamp_pit, stamp_speech;
   logic [TimeWidth-1:0] stamp_blaster, stamp_sample, stamp_fm;

   // video and interval timer state
   logic [LineWidth-1:0]                    line_now;
   logic [StatusWidth-1:0]                  status_now;
   logic [TotalWidth-1:0]                   lines_seen;
   logic [TimerCount-1:0][CountWidth-1:0]   pit_count;

   rsp_type     expected_q[$];
   int unsigned results_seen;

   // deadline test without wrapping: now must reach stamp + period
   function automatic bit period_elapsed(input logic [TimeWidth-1:0] now,
                                         input logic [TimeWidth-1:0] stamp,
                                         input logic [PeriodWidth-1:0] period);
      return (now >= stamp) && ((now - stamp) >= TimeWidth'(period));
   endfunction

   // one channel update per input item, result pushed for later comparison
   task automatic predict_item(input logic [TimeWidth-1:0] now,
                               input logic [TimerCount-1:0] active,
                               input logic [TimerCount-1:0][CountWidth-1:0] reload);
      rsp_type     want;
      int unsigned next_line;
      int          ch;
      want = '0;

      // scanline counter and status bits, re-armed to now
      if (period_elapsed(now, stamp_line, cfg.scanline_period)) begin
         next_line = (int'(line_now) + 1) % LinesPerFrame;
         line_now = LineWidth'(next_line);
         status_now = '0;
         status_now[RetraceBit] = (next_line > LastVisibleLine);
         status_now[OddLineBit] = line_now[0];
         lines_seen = lines_seen + 1'b1;
         stamp_line = now;
      end

      // irq request only while timer channel zero runs
      if (active[0] && period_elapsed(now, stamp_irq, cfg.irq0_period)) begin
         want.irq0_request = 1'b1;
         stamp_irq = now;
      end

      // timer counters: reload when low, then count down
      if (period_elapsed(now, stamp_pit, cfg.pit_period)) begin
         for (ch = 0; ch < TimerCount; ch++) begin
            if (active[ch]) begin
               if (pit_count[ch] < PitDecrement) pit_count[ch] = reload[ch];
               pit_count[ch] = pit_count[ch] - CountWidth'(PitDecrement);
            end
         end
         stamp_pit = now;
      end

      // audio channels re-arm by their period so they never drift
      if (period_elapsed(now, stamp_speech, cfg.speech_period)) begin
         want.speech_pulse = 1'b1;
         stamp_speech = stamp_speech + TimeWidth'(cfg.speech_period);
      end
      if (cfg.blaster_period != BlasterOff
          && period_elapsed(now, stamp_blaster, cfg.blaster_period)) begin
         want.blaster_pulse = 1'b1;
         stamp_blaster = stamp_blaster + TimeWidth'(cfg.blaster_period);
      end
      if (cfg.audio_mode != AUDIO_OFF
          && period_elapsed(now, stamp_sample, cfg.sample_period)) begin
         want.audio_pulses = (cfg.audio_mode == AUDIO_NORMAL) ? NormalTicks : SlowTicks;
         stamp_sample = stamp_sample + TimeWidth'(cfg.sample_period);
      end
      if (period_elapsed(now, stamp_fm, cfg.adlib_period)) begin
         want.fm_pulse = 1'b1;
         stamp_fm = stamp_fm + TimeWidth'(cfg.adlib_period);
      end

      want.line_number  = line_now;
      want.video_status = status_now;
      want.line_count   = lines_seen;
      want.count_zero   = pit_count[0];
      want.count_one    = pit_count[1];
      want.count_two    = pit_count[2];
      expected_q.push_back(want);
   endtask

   function automatic int unsigned field_diff(input string name, input logic [63:0] want,
                                              input logic [63:0] got, input bit report);
      if (want === got) return 0;
      if (report) $display("   %s: expected %0h, actual %0h", name, want, got);
      return 1;
   endfunction

   // compare one result item with the oldest expectation
   task automatic check_result(input rsp_type got);
      rsp_type     want;
      bit          report;
      int unsigned bad;
      results_seen++;
      report = (mismatch_count < MaxReports);
      if (expected_q.size() == 0) begin
         if (report) $display("result item %0d at %0t ns arrived with nothing expected",
                              results_seen, $time);
         mismatch_count++;
      end else begin
         want = expected_q.pop_front();
         if (report && want !== got)
            $display("result item %0d at %0t ns differs:", results_seen, $time);
         bad = field_diff("irq0_request", 64'(want.irq0_request),
                          64'(got.irq0_request), report)
             + field_diff("speech_pulse", 64'(want.speech_pulse),
                          64'(got.speech_pulse), report)
             + field_diff("blaster_pulse", 64'(want.blaster_pulse),
                          64'(got.blaster_pulse), report)
             + field_diff("audio_pulses", 64'(want.audio_pulses),
                          64'(got.audio_pulses), report)
             + field_diff("fm_pulse", 64'(want.fm_pulse), 64'(got.fm_pulse), report)
             + field_diff("line_number", 64'(want.line_number),
                          64'(got.line_number), report)
             + field_diff("video_status", 64'(want.video_status),
                          64'(got.video_status), report)
             + field_diff("line_count", 64'(want.line_count),
                          64'(got.line_count), report)
             + field_diff("count_zero", 64'(want.count_zero),
                          64'(got.count_zero), report)
             + field_diff("count_one", 64'(want.count_one),
                          64'(got.count_one), report)
             + field_diff("count_two", 64'(want.count_two),
                          64'(got.count_two), report);
         if (bad != 0) mismatch_count++;
      end
   endtask

   // register writes, item predictions and result checks on each edge
   always @(posedge clock) begin
      if (reset) begin
         cfg.scanline_period = DefaultPeriod;
         cfg.irq0_period     = DefaultPeriod;
         cfg.pit_period      = DefaultPeriod;
         cfg.speech_period   = DefaultPeriod;
         cfg.blaster_period  = BlasterOff;
         cfg.sample_period   = DefaultPeriod;
         cfg.adlib_period    = DefaultPeriod;
         cfg.audio_mode      = AUDIO_NORMAL;
         stamp_line    = '0;
         stamp_irq     = '0;
         stamp_pit     = '0;
         stamp_speech  = '0;
         stamp_blaster = '0;
         stamp_sample  = '0;
         stamp_fm      = '0;
         line_now      = '0;
         status_now    = '0;
         lines_seen    = '0;
         pit_count     = '0;
         expected_q.delete();
         results_seen   = 0;
         mismatch_count = 0;
         pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_idx_type'(csr_paddr[CsrAddrWidth-1:2]))
               REG_SCANLINE_PERIOD: cfg.scanline_period = csr_pwdata;
               REG_IRQ0_PERIOD:     cfg.irq0_period     = csr_pwdata;
               REG_PIT_PERIOD:      cfg.pit_period      = csr_pwdata;
               REG_SPEECH_PERIOD:   cfg.speech_period   = csr_pwdata;
               REG_BLASTER_PERIOD:  cfg.blaster_period  = csr_pwdata;
               REG_SAMPLE_PERIOD:   cfg.sample_period   = csr_pwdata;
               REG_ADLIB_PERIOD:    cfg.adlib_period    = csr_pwdata;
               REG_AUDIO_MODE: begin
                  cfg.audio_mode = audio_mode_type'(csr_pwdata[ModeWidth-1:0]);
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_item(req_now_time, req_timer_active,
                         {req_reload_two, req_reload_one, req_reload_zero});
         if (rsp_valid && !rsp_stall)
            check_result({rsp_irq0_request, rsp_speech_pulse, rsp_blaster_pulse,
                          rsp_audio_pulses, rsp_fm_pulse, rsp_line_number,
                          rsp_video_status, rsp_line_count, rsp_count_zero,
                          rsp_count_one, rsp_count_two});
         pending <= expected_q.size();
      end
   end

endmodule

>>> test/tb_multi_rate_event_scheduler.sv
// testbench top for the multi-rate event scheduler: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_multi_rate_event_scheduler;
   import mres_pkg::*;

   localparam int unsigned IdleLimit   = 2000;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned PhaseItems  = 52;

   // register settings and the time steps that go with them
   typedef enum int unsigned {
      SHAPE_DEFAULT,
      SHAPE_TINY,
      SHAPE_ZERO,
      SHAPE_MIN,
      SHAPE_MIXED,
      SHAPE_WIDE,
      SHAPE_FULL,
      SHAPE_TOP
   } shape_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   logic [TimeWidth-1:0]    req_now_time     = '0;
   logic [TimerCount-1:0]   req_timer_active = '0;
   logic [CountWidth-1:0]   req_reload_zero  = '0;
   logic [CountWidth-1:0]   req_reload_one   = '0;
   logic [CountWidth-1:0]   req_reload_two   = '0;

   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_irq0_request;
   logic                    rsp_speech_pulse;
   logic                    rsp_blaster_pulse;
   logic [PulseWidth-1:0]   rsp_audio_pulses;
   logic                    rsp_fm_pulse;
   logic [LineWidth-1:0]    rsp_line_number;
   logic [StatusWidth-1:0]  rsp_video_status;
   logic [TotalWidth-1:0]   rsp_line_count;
   logic [CountWidth-1:0]   rsp_count_zero;
   logic [CountWidth-1:0]   rsp_count_one;
   logic [CountWidth-1:0]   rsp_count_two;

   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   int unsigned     mismatches;
   int unsigned     pending;
   int unsigned     idle_cycles = 0;
   int unsigned     stall_left  = 0;
   stall_style_type stall_style = STALL_NONE;

   logic [TimeWidth-1:0] host_time;
   int unsigned          items_sent;
   int unsigned          settings_used;

   always #5 clock = ~clock;

   multi_rate_event_scheduler u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_now_time      (req_now_time),
      .req_timer_active  (req_timer_active),
      .req_reload_zero   (req_reload_zero),
      .req_reload_one    (req_reload_one),
      .req_reload_two    (req_reload_two),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_irq0_request  (rsp_irq0_request),
      .rsp_speech_pulse  (rsp_speech_pulse),
      .rsp_blaster_pulse (rsp_blaster_pulse),
      .rsp_audio_pulses  (rsp_audio_pulses),
      .rsp_fm_pulse      (rsp_fm_pulse),
      .rsp_line_number   (rsp_line_number),
      .rsp_video_status  (rsp_video_status),
      .rsp_line_count    (rsp_line_count),
      .rsp_count_zero    (rsp_count_zero),
      .rsp_count_one     (rsp_count_one),
      .rsp_count_two     (rsp_count_two),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   mres_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_now_time      (req_now_time),
      .req_timer_active  (req_timer_active),
      .req_reload_zero   (req_reload_zero),
      .req_reload_one    (req_reload_one),
      .req_reload_two    (req_reload_two),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_irq0_request  (rsp_irq0_request),
      .rsp_speech_pulse  (rsp_speech_pulse),
      .rsp_blaster_pulse (rsp_blaster_pulse),
      .rsp_audio_pulses  (rsp_audio_pulses),
      .rsp_fm_pulse      (rsp_fm_pulse),
      .rsp_line_number   (rsp_line_number),
      .rsp_video_status  (rsp_video_status),
      .rsp_line_count    (rsp_line_count),
      .rsp_count_zero    (rsp_count_zero),
      .rsp_count_one     (rsp_count_one),
      .rsp_count_two     (rsp_count_two),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .mismatch_count    (mismatches),
      .pending           (pending)
   );

   // receiver stalls in stretches of changing style
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         stall_left  <= $urandom_range(16, 96);
         rsp_stall   <= 1'b0;
      end else begin
         stall_left <= stall_left - 1;
         case (stall_style)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // watchdog on cycles in which nothing moves
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("watchdog: nothing accepted for %0d cycles, %0d results outstanding",
                  idle_cycles, pending);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // present one item and hold it until it is taken
   task automatic send_item(input logic [TimeWidth-1:0] now,
                            input logic [TimerCount-1:0] active,
                            input logic [CountWidth-1:0] r0,
                            input logic [CountWidth-1:0] r1,
                            input logic [CountWidth-1:0] r2);
      req_valid        <= 1'b1;
      req_now_time     <= now;
      req_timer_active <= active;
      req_reload_zero  <= r0;
      req_reload_one   <= r1;
      req_reload_two   <= r2;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // reload values lean towards the edges and small numbers
   function automatic logic [CountWidth-1:0] pick_reload();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return CountWidth'($urandom_range(0, 30));
         default: return CountWidth'($urandom);
      endcase
   endfunction

   function automatic logic [TimeWidth-1:0] pick_step(input shape_type shape);
      case (shape)
         SHAPE_DEFAULT:       return TimeWidth'($urandom_range(0, 3000));
         SHAPE_TINY:          return TimeWidth'($urandom_range(0, 40));
         SHAPE_ZERO,
         SHAPE_MIN:           return TimeWidth'($urandom_range(0, 3));
         SHAPE_MIXED:         return TimeWidth'($urandom_range(0, 6000));
         SHAPE_WIDE: begin
            if ($urandom_range(0, 3) == 0)
               return 64'h1_0000_0000 + TimeWidth'($urandom_range(0, 32'h7FFF_FFFF));
            return TimeWidth'($urandom_range(0, 32'h3FFF_FFFF));
         end
         default:             return {31'd0, 1'($urandom), 32'($urandom)};
      endcase
   endfunction

   // mostly forward time, now and then a step back
   task automatic send_step(input logic [TimeWidth-1:0] step);
      logic [TimeWidth-1:0] back;
      logic [TimeWidth-1:0] now;
      if ($urandom_range(0, 9) == 0) begin
         back = TimeWidth'($urandom_range(1, 2000));
         now  = (back > host_time) ? '0 : host_time - back;
      end else begin
         host_time = host_time + step;
         now = host_time;
      end
      send_item(now, TimerCount'($urandom), pick_reload(), pick_reload(), pick_reload());
   endtask

   // random items in bursts with gaps between them
   task automatic run_phase(input shape_type shape);
      int unsigned n;
      int unsigned burst;
      int unsigned gap;
      n = 0;
      while (n < PhaseItems) begin
         burst = $urandom_range(1, 16);
         while (burst != 0 && n < PhaseItems) begin
            send_step(pick_step(shape));
            n++;
            burst--;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // drop valid and let every outstanding result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input reg_idx_type idx, input logic [CsrDataWidth-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [PeriodWidth-1:0] line_p,
                            input logic [PeriodWidth-1:0] irq_p,
                            input logic [PeriodWidth-1:0] pit_p,
                            input logic [PeriodWidth-1:0] speech_p,
                            input logic [PeriodWidth-1:0] blaster_p,
                            input logic [PeriodWidth-1:0] sample_p,
                            input logic [PeriodWidth-1:0] adlib_p,
                            input audio_mode_type mode);
      write_reg(REG_SCANLINE_PERIOD, line_p);
      write_reg(REG_IRQ0_PERIOD, irq_p);
      write_reg(REG_PIT_PERIOD, pit_p);
      write_reg(REG_SPEECH_PERIOD, speech_p);
      write_reg(REG_BLASTER_PERIOD, blaster_p);
      write_reg(REG_SAMPLE_PERIOD, sample_p);
      write_reg(REG_ADLIB_PERIOD, adlib_p);
      write_reg(REG_AUDIO_MODE, CsrDataWidth'(mode));
   endtask

   // new register setting once the block has gone quiet
   task automatic load_setting(input shape_type shape);
      wait_idle();
      settings_used++;
      case (shape)
         SHAPE_DEFAULT:
            write_all(DefaultPeriod, DefaultPeriod, DefaultPeriod, DefaultPeriod,
                      BlasterOff, DefaultPeriod, DefaultPeriod, AUDIO_NORMAL);
         SHAPE_TINY:
            write_all($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                      $urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                      $urandom_range(1, 16), AUDIO_SLOW);
         SHAPE_ZERO:
            write_all('0, '0, '0, '0, BlasterOff, '0, '0, AUDIO_OFF);
         SHAPE_MIN:
            write_all(1, 1, 1, 1, 1, 1, 1, AUDIO_SPARE);
         SHAPE_MIXED:
            write_all($urandom_range(1, 500), $urandom_range(1, 4000),
                      $urandom_range(1, 4000), $urandom_range(1, 4000),
                      $urandom_range(0, 4000), $urandom_range(1, 4000),
                      $urandom_range(1, 4000), audio_mode_type'($urandom_range(0, 3)));
         SHAPE_WIDE:
            write_all(1, '1, '1, '1, '1, '1, '1, AUDIO_NORMAL);
         SHAPE_FULL:
            write_all($urandom_range(1, 32'h10_0000), $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, audio_mode_type'($urandom_range(0, 3)));
         default:
            write_all('1, 1, 32'h8000_0000, '1, '1, DefaultPeriod, '1, AUDIO_SLOW);
      endcase
   endtask

   // climb to the top of the time range, ending with items at the largest time and just below it
   task automatic run_top_range();
      int k;
      for (k = 1; k <= 15; k++) begin
         host_time = {8'(k * 16), 24'($urandom), 32'($urandom)};
         send_item(host_time, TimerCount'($urandom), pick_reload(), pick_reload(),
                   pick_reload());
         if ($urandom_range(0, 3) == 0)
            send_item(host_time - TimeWidth'($urandom_range(1, 1000)), TimerCount'($urandom),
                      pick_reload(), pick_reload(), pick_reload());
      end
      host_time = '1;
      send_item(host_time, '1, pick_reload(), pick_reload(), pick_reload());
      // stamps now sit at the top, so stamp plus period lies beyond the range
      send_item(host_time, '1, pick_reload(), pick_reload(), pick_reload());
      send_item(host_time - 1, '1, pick_reload(), pick_reload(), pick_reload());
   endtask

   initial begin
      items_sent    = 0;
      settings_used = 1;
      host_time     = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items on the reset setting
      send_item(64'd0, 3'b111, 16'h0000, 16'h0000, 16'h0000);
      send_item(64'd999, 3'b111, 16'hFFFF, 16'h0000, 16'h0005);
      send_item(64'd1000, 3'b111, 16'hFFFF, 16'h0000, 16'h0005);
      // time going backwards, then the same time again
      send_item(64'd500, 3'b111, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(64'd1000, 3'b110, 16'h1234, 16'h0009, 16'h000A);
      // all timer channels idle: no irq and counters held
      send_item(64'd2000, 3'b000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(64'd3000, 3'b001, 16'h0009, 16'h000A, 16'h0014);
      send_item(64'd3000000, 3'b111, 16'h0009, 16'h000A, 16'h0014);
      send_item(64'd3001000, 3'b111, 16'h000A, 16'h000B, 16'hFFFE);

      // blaster on with slow audio, then audio off, then the spare mode
      wait_idle();
      write_reg(REG_BLASTER_PERIOD, 32'd1);
      write_reg(REG_AUDIO_MODE, CsrDataWidth'(AUDIO_SLOW));
      settings_used++;
      send_item(64'd3001500, 3'b101, 16'h0003, 16'h0004, 16'h0005);
      send_item(64'd3002000, 3'b010, 16'h0003, 16'h0004, 16'h0005);
      wait_idle();
      write_reg(REG_AUDIO_MODE, CsrDataWidth'(AUDIO_OFF));
      settings_used++;
      send_item(64'd3003000, 3'b111, 16'h8000, 16'h7FFF, 16'h0001);
      send_item(64'd3004000, 3'b111, 16'h8000, 16'h7FFF, 16'h0001);
      wait_idle();
      write_reg(REG_AUDIO_MODE, CsrDataWidth'(AUDIO_SPARE));
      settings_used++;
      send_item(64'd3005000, 3'b011, 16'h5555, 16'hAAAA, 16'h0000);
      host_time = 64'd3005000;

      // random phases, one register setting each
      load_setting(SHAPE_DEFAULT);
      run_phase(SHAPE_DEFAULT);
      load_setting(SHAPE_TINY);
      run_phase(SHAPE_TINY);
      load_setting(SHAPE_ZERO);
      run_phase(SHAPE_ZERO);
      load_setting(SHAPE_MIN);
      run_phase(SHAPE_MIN);
      load_setting(SHAPE_MIXED);
      run_phase(SHAPE_MIXED);
      load_setting(SHAPE_WIDE);
      run_phase(SHAPE_WIDE);
      load_setting(SHAPE_FULL);
      run_phase(SHAPE_FULL);
      load_setting(SHAPE_TOP);
      run_top_range();

      wait_idle();
      $display("run covered %0d input items over %0d register settings", items_sent,
               settings_used);
      $display("incl. backward time, zero and full-width periods, all audio modes, top times");
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/mres_pkg.sv
rtl/mres_due.sv
rtl/mres_csr.sv
rtl/mres_core.sv
rtl/multi_rate_event_scheduler.sv
test/mres_checker.sv
test/tb_multi_rate_event_scheduler.sv
